// File: src/crib_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crib_pkg
// shared types, constants and crc helpers for the config rom image builder
// ----------------------------------------------------------------------------
package crib_pkg;

  localparam logic [31:0] NAME_1394    = 32'h3133_3934;
  localparam logic [7:0]  BIB_LENGTHS  = 8'h04;
  localparam logic [1:0]  TYPE_IMMED   = 2'b00;
  localparam logic [5:0]  KEY_VENDOR   = 6'h03;
  localparam logic [5:0]  KEY_NODECAPS = 6'h0C;
  localparam int          FIFO_DEPTH   = 2;

  localparam logic [2:0] QI_BIB_HDR  = 3'd0;
  localparam logic [2:0] QI_NAME     = 3'd1;
  localparam logic [2:0] QI_OPTS     = 3'd2;
  localparam logic [2:0] QI_GUID_HI  = 3'd3;
  localparam logic [2:0] QI_GUID_LO  = 3'd4;
  localparam logic [2:0] QI_DIR_HDR  = 3'd5;
  localparam logic [2:0] QI_VENDOR   = 3'd6;
  localparam logic [2:0] QI_NODECAPS = 3'd7;

  typedef struct packed {
    logic [31:0] opts;
    logic [31:0] ghi;
    logic [31:0] glo;
    logic [15:0] crc_bus;
    logic [15:0] crc_dir;
    logic        caps;
    logic [2:0]  last_idx;
  } crib_job_t;

  // crc-16 0x1021, one byte msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    crc_byte = {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

  function automatic logic [15:0] crc_quad(input logic [15:0] crc, input logic [31:0] q);
    logic [15:0] c;
    c = crc_byte(crc, q[31:24]);
    c = crc_byte(c, q[23:16]);
    c = crc_byte(c, q[15:8]);
    c = crc_byte(c, q[7:0]);
    crc_quad = c;
  endfunction

  function automatic logic [31:0] vendor_entry(input logic [31:0] ghi);
    vendor_entry = {TYPE_IMMED, KEY_VENDOR, ghi[31:8]};
  endfunction

  function automatic logic [31:0] nodecaps_entry(input logic [31:0] opts);
    nodecaps_entry = {TYPE_IMMED, KEY_NODECAPS, opts[23:0]};
  endfunction

endpackage
`default_nettype wire

// File: src/config_rom_image_builder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// config_rom_image_builder_top
// builds an ieee 1394 configuration rom image from one request per transfer
// ----------------------------------------------------------------------------
// Each input transfer carries bus options, the 64-bit guid and two flags; the
// block answers with the rom image as 5, 7 or 8 output transfers (bus info
// block only, plus root directory, plus node capabilities), quad_index
// counting from 0 and tlast on the final quadlet. The front computes both
// crc-16 values, one quadlet per cycle, and hands the job through a two-entry
// queue to the back, which sends one quadlet per cycle unless out_tready
// stalls it. Sustained throughput is therefore set by the back's output
// register; the first quadlet passes the front's crc steps, the queue and the
// back's job and output registers. No state carries over between requests.
module config_rom_image_builder_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [95:0] in_tdata,   // bus_options, guid_high, guid_low
  input  wire  [1:0]  in_tuser,   // with_root_dir, with_node_caps
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // quad_index, quad_value, zero pad
  output logic        out_tlast
);
  import crib_pkg::*;

  logic        push_valid;
  logic        push_ready;
  crib_job_t   push_job;
  logic        pop_valid;
  logic        pop_ready;
  crib_job_t   pop_job;
  logic [2:0]  quad_index;
  logic [31:0] quad_value;

  crib_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_opts    (in_tdata[31:0]),
    .in_ghi     (in_tdata[63:32]),
    .in_glo     (in_tdata[95:64]),
    .in_root    (in_tuser[0]),
    .in_caps    (in_tuser[1]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  crib_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  crib_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_idx    (quad_index),
    .out_value  (quad_value),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b00000, quad_value, quad_index};

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      quad_index == QI_GUID_LO || quad_index == QI_VENDOR || quad_index == QI_NODECAPS)
    else $error("tlast on a quadlet that cannot end an image");

  a_bib_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && quad_index == QI_BIB_HDR |-> quad_value[31:16] == {BIB_LENGTHS, BIB_LENGTHS})
    else $error("bus info header lengths wrong");

  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && !push_ready |=> push_valid)
    else $error("front dropped a job while the queue was full");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && quad_index == $past(quad_index) + 3'd1)
    else $error("quadlet index did not advance by one");

endmodule
`default_nettype wire

// File: src/crib_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crib_front
// takes build requests and runs both crcs, one quadlet per cycle
// ----------------------------------------------------------------------------
module crib_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [31:0]           in_opts,
  input  wire [31:0]           in_ghi,
  input  wire [31:0]           in_glo,
  input  wire                  in_root,
  input  wire                  in_caps,
  output logic                 push_valid,
  input  wire                  push_ready,
  output crib_pkg::crib_job_t  push_job
);
  import crib_pkg::*;

  logic        busy_r,    busy_nxt;
  logic [1:0]  step_r,    step_nxt;
  logic [31:0] opts_r,    opts_nxt;
  logic [31:0] ghi_r,     ghi_nxt;
  logic [31:0] glo_r,     glo_nxt;
  logic        root_r,    root_nxt;
  logic        caps_r,    caps_nxt;
  logic [15:0] crc_bus_r, crc_bus_nxt;
  logic [15:0] crc_dir_r, crc_dir_nxt;
  logic [31:0] bus_quad;
  logic [15:0] crc_bus_step;
  logic        last_step;
  logic        done;
  logic        take;

  assign last_step  = (step_r == 2'd3);
  assign push_valid = busy_r && last_step;
  assign done       = push_valid && push_ready;
  assign in_ready   = !busy_r || done;
  assign take       = in_valid && in_ready;

  always_comb begin
    unique case (step_r)
      2'd0: bus_quad = NAME_1394;
      2'd1: bus_quad = opts_r;
      2'd2: bus_quad = ghi_r;
      2'd3: bus_quad = glo_r;
      default: bus_quad = glo_r;
    endcase
  end

  assign crc_bus_step = crc_quad(crc_bus_r, bus_quad);

  always_comb begin
    push_job.opts     = opts_r;
    push_job.ghi      = ghi_r;
    push_job.glo      = glo_r;
    push_job.crc_bus  = crc_bus_step;
    push_job.crc_dir  = crc_dir_r;
    push_job.caps     = root_r && caps_r;
    push_job.last_idx = !root_r ? QI_GUID_LO : (caps_r ? QI_NODECAPS : QI_VENDOR);
  end

  always_comb begin
    busy_nxt    = busy_r;
    step_nxt    = step_r;
    opts_nxt    = opts_r;
    ghi_nxt     = ghi_r;
    glo_nxt     = glo_r;
    root_nxt    = root_r;
    caps_nxt    = caps_r;
    crc_bus_nxt = crc_bus_r;
    crc_dir_nxt = crc_dir_r;
    if (take) begin
      busy_nxt    = 1'b1;
      step_nxt    = 2'd0;
      opts_nxt    = in_opts;
      ghi_nxt     = in_ghi;
      glo_nxt     = in_glo;
      root_nxt    = in_root;
      caps_nxt    = in_caps;
      crc_bus_nxt = 16'h0000;
      crc_dir_nxt = 16'h0000;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !last_step) begin
      step_nxt    = step_r + 2'd1;
      crc_bus_nxt = crc_bus_step;
      if (step_r == 2'd0) begin
        crc_dir_nxt = crc_quad(crc_dir_r, vendor_entry(ghi_r));
      end else if (step_r == 2'd1 && caps_r) begin
        crc_dir_nxt = crc_quad(crc_dir_r, nodecaps_entry(opts_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opts_r    <= opts_nxt;
    ghi_r     <= ghi_nxt;
    glo_r     <= glo_nxt;
    root_r    <= root_nxt;
    caps_r    <= caps_nxt;
    crc_bus_r <= crc_bus_nxt;
    crc_dir_r <= crc_dir_nxt;
  end

endmodule
`default_nettype wire

// File: src/crib_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crib_fifo
// two-entry job queue between the crc front and the quadlet back
// ----------------------------------------------------------------------------
module crib_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  crib_pkg::crib_job_t  push_job,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output crib_pkg::crib_job_t  pop_job
);
  import crib_pkg::*;

  crib_job_t   mem [FIFO_DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r,  count_nxt;
  logic        push;
  logic        pop;

  assign push_ready = (count_r != 2'(FIFO_DEPTH));
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// File: src/crib_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crib_back
// walks one queued job and sends its rom image, one quadlet per cycle unless out_ready stalls it
// ----------------------------------------------------------------------------
module crib_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  pop_valid,
  output logic                 pop_ready,
  input  crib_pkg::crib_job_t  pop_job,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [2:0]           out_idx,
  output logic [31:0]          out_value,
  output logic                 out_last
);
  import crib_pkg::*;

  logic        busy_r,      busy_nxt;
  crib_job_t   job_r,       job_nxt;
  logic [2:0]  idx_r,       idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_idx_r,   out_idx_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic        out_last_r,  out_last_nxt;
  logic        adv;
  logic        is_last;
  logic        pop;
  logic [31:0] quad;

  assign adv       = !out_valid_r || out_ready;
  assign is_last   = (idx_r == job_r.last_idx);
  assign pop_ready = adv && (!busy_r || is_last);
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    unique case (idx_r)
      QI_BIB_HDR:  quad = {BIB_LENGTHS, BIB_LENGTHS, job_r.crc_bus};
      QI_NAME:     quad = NAME_1394;
      QI_OPTS:     quad = job_r.opts;
      QI_GUID_HI:  quad = job_r.ghi;
      QI_GUID_LO:  quad = job_r.glo;
      QI_DIR_HDR:  quad = {14'h0000, job_r.caps, !job_r.caps, job_r.crc_dir};
      QI_VENDOR:   quad = vendor_entry(job_r.ghi);
      QI_NODECAPS: quad = nodecaps_entry(job_r.opts);
      default:     quad = NAME_1394;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      out_idx_nxt   = idx_r;
      out_value_nxt = quad;
      out_last_nxt  = is_last;
      if (busy_r && !is_last) begin
        idx_nxt = idx_r + 3'd1;
      end else if (busy_r) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      job_nxt  = pop_job;
      idx_nxt  = QI_BIB_HDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    idx_r       <= idx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ieee 1394 configuration rom image builder
// ----------------------------------------------------------------------------
// Requests are sent in random bursts and gaps, after a short directed set that
// covers the field extremes and every flag combination. Each accepted request
// is expanded into its rom image by a local crc-16 model. Every output
// transfer is checked against the oldest expected quadlet while the receiver
// stalls on a pattern of its own.
module tb;
  import crib_pkg::*;

  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam int          N_RANDOM   = 250;

  typedef struct {
    logic [31:0] opts;
    logic [31:0] ghi;
    logic [31:0] glo;
    logic        root;
    logic        caps;
    logic        drain;
  } rom_req_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] value;
    logic        last;
  } rom_quad_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [95:0] in_tdata = '0;   // bus_options, guid_high, guid_low
  logic [1:0]  in_tuser = '0;   // with_root_dir, with_node_caps
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [39:0] out_tdata;       // quad_index, quad_value, zero pad
  wire         out_tlast;

  rom_req_t  req_pend[$];
  rom_quad_t quad_exp[$];
  rom_req_t  cur_req;
  logic      drv_go;
  int        gap_left = 0;
  int        burst_left = 0;
  logic [9:0] stall_cyc = '0;
  int        mismatches = 0;
  int        quads_checked = 0;
  int        reqs_sent = 0;
  int        n_bib_only = 0;
  int        n_dir = 0;
  int        n_caps = 0;

  config_rom_image_builder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] crc16_doublet(input logic [15:0] crc,
                                                input logic [15:0] d);
    logic [15:0] c;
    c = crc ^ d;
    for (int b = 0; b < 16; b++)
      c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [15:0] crc16_span(input logic [31:0] rom [8],
                                             input int first, input int n);
    logic [15:0] c;
    c = '0;
    for (int i = first; i < first + n; i++) begin
      c = crc16_doublet(c, rom[i][31:16]);
      c = crc16_doublet(c, rom[i][15:0]);
    end
    return c;
  endfunction

  task automatic predict_image(input rom_req_t r);
    logic [31:0] rom [8];
    int          n;
    rom_quad_t   q;
    for (int i = 0; i < 8; i++) rom[i] = '0;
    rom[QI_NAME]    = NAME_1394;
    rom[QI_OPTS]    = r.opts;
    rom[QI_GUID_HI] = r.ghi;
    rom[QI_GUID_LO] = r.glo;
    rom[QI_BIB_HDR] = {BIB_LENGTHS, BIB_LENGTHS, crc16_span(rom, 1, 4)};
    n = 5;
    if (r.root) begin
      rom[QI_VENDOR] = {TYPE_IMMED, KEY_VENDOR, r.ghi[31:8]};
      n = 7;
      if (r.caps) begin
        rom[QI_NODECAPS] = {TYPE_IMMED, KEY_NODECAPS, r.opts[23:0]};
        n = 8;
      end
      rom[QI_DIR_HDR] = {16'(n - 6), crc16_span(rom, 6, n - 6)};
    end
    case (n)
      5: n_bib_only++;
      7: n_dir++;
      default: n_caps++;
    endcase
    for (int k = 0; k < n; k++) begin
      q.idx   = 3'(k);
      q.value = rom[k];
      q.last  = (k == n - 1);
      quad_exp.push_back(q);
    end
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [31:0] opts, input logic [31:0] ghi,
                         input logic [31:0] glo, input logic root,
                         input logic caps, input logic drain);
    rom_req_t r;
    r.opts  = opts;
    r.ghi   = ghi;
    r.glo   = glo;
    r.root  = root;
    r.caps  = caps;
    r.drain = drain;
    req_pend.push_back(r);
  endtask

  // stimulus
  initial begin
    for (int f = 0; f < 4; f++) begin
      add_req('0, '0, '0, f[0], f[1], 1'b0);
      add_req('1, '1, '1, f[0], f[1], 1'b0);
    end
    add_req(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0);
    add_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 1'b0);
    add_req(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
    add_req(32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1, 1'b0);
    add_req(32'hFF00_0000, 32'h0000_00FF, 32'h1234_5678, 1'b1, 1'b1, 1'b0);
    add_req(32'h00FF_FFFF, 32'hFFFF_FF00, 32'h8765_4321, 1'b1, 1'b1, 1'b0);
    add_req($urandom, $urandom, $urandom, 1'b0, 1'b1, 1'b0);
    add_req($urandom, $urandom, $urandom, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < N_RANDOM; i++)
      add_req(rand_word(), rand_word(), rand_word(), $urandom_range(0, 3) != 0,
              1'($urandom_range(0, 1)), (i % 60) == 30);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (req_pend.size() > 0 || in_tvalid) @(posedge clk);
    while (quad_exp.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d requests: %0d bus info only, %0d with directory, %0d with node caps",
             reqs_sent, n_bib_only, n_dir, n_caps);
    $display("%0d quadlets checked, %0d mismatches", quads_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d requests pending, %0d quadlets expected",
             req_pend.size(), quad_exp.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_image(cur_req);
        reqs_sent++;
      end
      if (!in_tvalid || in_tready) begin
        drv_go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_pend.size() > 0 && !(req_pend[0].drain && quad_exp.size() > 0)) begin
          drv_go = 1'b1;
        end
        if (drv_go) begin
          cur_req = req_pend.pop_front();
          in_tdata <= {cur_req.glo, cur_req.ghi, cur_req.opts};
          in_tuser <= {cur_req.caps, cur_req.root};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_tvalid <= drv_go;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall_cyc <= stall_cyc + 1'b1;
      case (stall_cyc[9:7])
        0, 1: out_tready <= 1'b1;
        2: out_tready <= 1'($urandom_range(0, 1));
        3: out_tready <= (stall_cyc[1:0] != 0);
        4: out_tready <= (stall_cyc[3:0] < 4);
        5: out_tready <= ($urandom_range(0, 7) != 0);
        default: out_tready <= stall_cyc[0];
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (quad_exp.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer idx=%0d value=%08h last=%0b",
                                out_tdata[2:0], out_tdata[34:3], out_tlast));
      end else begin
        if (out_tdata[2:0] != quad_exp[0].idx || out_tdata[34:3] != quad_exp[0].value ||
            out_tlast != quad_exp[0].last)
          note_mismatch($sformatf("want idx=%0d value=%08h last=%0b, got idx=%0d value=%08h last=%0b",
                                  quad_exp[0].idx, quad_exp[0].value, quad_exp[0].last,
                                  out_tdata[2:0], out_tdata[34:3], out_tlast));
        void'(quad_exp.pop_front());
        quads_checked++;
      end
    end
  end

endmodule
`default_nettype wire
